/* sv/assert_macros.svh */
// Shared assertion macros. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ITT_CHECK(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define ITT_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/itt_pkg.sv */
package itt_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 8'h37;
	localparam logic [CHAR_W-1:0] CHAR_MINUS       = 8'h2D;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] number;
		logic [RADIX_W-1:0]           radix;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} chr_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic bit_done;
		logic quo_zero;
		logic show_sign;
		logic idx_zero;
		logic out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		if (d > DECIMAL - 6'd1) begin
			return CHAR_LETTER_BASE + dw;
		end
		return CHAR_ZERO + dw;
	endfunction

endpackage

/* sv/itt_dpath.sv */
`include "assert_macros.svh"

module itt_dpath (
	input  logic         clk,
	input  logic         arst_n,
	input  itt_pkg::req_t req,
	input  itt_pkg::cmd_t cmd,
	output itt_pkg::sts_t sts,
	output logic         chr_valid,
	input  logic         chr_ready,
	output itt_pkg::chr_t chr
);
	import itt_pkg::*;

	logic [VALUE_BITS-1:0] num_u;
	logic [VALUE_BITS-1:0] mag;
	logic [RADIX_W-1:0]    radix_c;

	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    radix_q;
	logic                  neg_dec_q;
	logic [IDX_W-1:0]      bit_q;
	logic [IDX_W-1:0]      wr_q;
	logic [IDX_W-1:0]      rd_q;

	logic [RADIX_W:0]      trial;
	logic [RADIX_W:0]      diff;
	logic                  ge;
	logic [RADIX_W-1:0]    rem_d;

	logic [RADIX_W-1:0]    dig_mem [VALUE_BITS];

	chr_t                  chr_q;
	logic                  chr_valid_q;

	assign num_u = req.number;
	assign mag   = num_u[VALUE_BITS-1] ? (~num_u + 1'b1) : num_u;

	always_comb begin
		if (req.radix < RADIX_MIN) begin
			radix_c = RADIX_MIN;
		end else if (req.radix > RADIX_MAX) begin
			radix_c = RADIX_MAX;
		end else begin
			radix_c = req.radix;
		end
	end

	// one restoring division step per cycle
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= {1'b0, radix_q};
	assign diff  = trial - {1'b0, radix_q};
	assign rem_d = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			radix_q <= RADIX_MIN;
			bit_q   <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else if (cmd.load) begin
			rem_q   <= '0;
			radix_q <= radix_c;
			bit_q   <= '0;
			wr_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
			bit_q <= bit_q + 1'b1;
		end else if (cmd.store) begin
			// hold the digit, restart the remainder for the next one
			rem_q <= '0;
			bit_q <= '0;
			wr_q  <= wr_q + 1'b1;
			rd_q  <= wr_q;
		end else if (cmd.emit_digit) begin
			rd_q <= rd_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q     <= mag;
			neg_dec_q <= num_u[VALUE_BITS-1] && (radix_c == DECIMAL);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			dig_mem[wr_q] <= rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			chr_q.character <= CHAR_MINUS;
			chr_q.last      <= 1'b0;
		end else if (cmd.emit_digit) begin
			chr_q.character <= digit_char(dig_mem[rd_q]);
			chr_q.last      <= (rd_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			chr_valid_q <= 1'b1;
		end else if (chr_ready) begin
			chr_valid_q <= 1'b0;
		end
	end

	assign sts.bit_done  = (bit_q == IDX_W'(VALUE_BITS - 1));
	assign sts.quo_zero  = (quo_q == '0);
	assign sts.show_sign = neg_dec_q;
	assign sts.idx_zero  = (rd_q == '0);
	assign sts.out_free  = !chr_valid_q || chr_ready;

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

	`ITT_CHECK(a_rem_below_radix, 1'b1, rem_q < radix_q, "remainder reached the radix")
	`ITT_CHECK(a_no_overwrite, chr_valid_q && !chr_ready,
		!(cmd.emit_sign || cmd.emit_digit), "pending character overwritten")

endmodule

/* sv/itt_ctrl.sv */
`include "assert_macros.svh"

module itt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  itt_pkg::sts_t sts,
	output itt_pkg::cmd_t cmd
);
	import itt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_STORE = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.bit_done) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (!sts.quo_zero) begin
					state_d = ST_DIV;
				end else if (sts.show_sign) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ITT_CHECK_NEXT(a_accept_starts_div, req_valid && req_ready, state_q == ST_DIV,
		"accepted request did not start division")
	`ITT_CHECK_NEXT(a_final_digit_idles, cmd.emit_digit && sts.idx_zero,
		state_q == ST_IDLE, "controller did not idle after final digit")

endmodule

/* sv/integer_to_text_in_base_top.sv */
// Converts a signed 32-bit number to ASCII text in a base of 2 to 36 (out-of-range
// bases clamp into that range), one character per output transfer, most significant
// digit first, with last set on the final character; digits above 9 are 'A'..'Z',
// zero gives "0", and only base 10 prints a leading '-' for negative values (other
// bases print the magnitude). Each digit is computed by the shared one-bit-per-
// cycle restoring divider (32 steps, then a store of the remainder); the characters
// then leave one at a time, the minus sign (if any) first, each waiting while the
// output register still holds a character that has not been accepted.
// A new request is taken once the final character has been loaded into the output
// register.
module integer_to_text_in_base_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  itt_pkg::req_t req,
	output logic          chr_valid,
	input  logic          chr_ready,
	output itt_pkg::chr_t chr
);
	import itt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	itt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr)
	);

endmodule
